// ===== rtl/assert_macros.svh =====
// assertion macros used by the hash table core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// types, codes and defaults for the chained hash table
package cht_pkg;

    // default sizes
    localparam int BUCKETS_DEF      = 16;
    localparam int POOL_NODES_DEF   = 64;
    localparam int PAYLOAD_BITS_DEF = 64;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    // command codes (the unused code acts as a search)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAY_W-1:0]    found_payload;
        logic [CNT_W-1:0]    entry_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_WALK,
        ST_MISS,
        ST_POP,
        ST_FREE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/cht_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
module cht_ram
    import cht_pkg::*;
#(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = BUCKETS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cht_bucket_mod.sv =====
// bucket index unit: key magnitude modulo the bucket count
module cht_bucket_mod
    import cht_pkg::*;
#(
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [KEY_W-1:0]    mag,
    output logic                done,
    output logic [BUCKET_W-1:0] bucket
);

    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic                done_reg;
            logic [BUCKET_W-1:0] bucket_reg;

            // power of two: remainder is a mask
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    bucket_reg <= BUCKET_W'(mag & KEY_W'(BUCKETS - 1));
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end else begin : g_recip
            // byte fold, reciprocal multiply, subtract, each step registered
            localparam int S_W   = BUCKET_W + 10;
            localparam int M_W   = S_W + 1;
            localparam int Q_W   = S_W - BUCKET_W + 1;
            localparam int P_W   = S_W + M_W;
            localparam int SHIFT = S_W + BUCKET_W;
            localparam logic [63:0] RECIP =
                ((64'd1 << SHIFT) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
            localparam logic [S_W-1:0] RES0  = S_W'(1 % BUCKETS);
            localparam logic [S_W-1:0] RES1  = S_W'(256 % BUCKETS);
            localparam logic [S_W-1:0] RES2  = S_W'(65536 % BUCKETS);
            localparam logic [S_W-1:0] RES3  = S_W'((1 << 24) % BUCKETS);
            localparam logic [S_W-1:0] DIV_S = S_W'(BUCKETS);

            logic                fold_v_reg;
            logic                quot_v_reg;
            logic                done_reg;
            logic [S_W-1:0]      fold_reg;
            logic [Q_W-1:0]      quot_reg;
            logic [BUCKET_W-1:0] rem_reg;
            logic [S_W-1:0]      fold_w;
            logic [P_W-1:0]      prod_w;
            logic [S_W-1:0]      rem_w;

            // each byte weighted by its place residue, same remainder in fewer bits
            assign fold_w = S_W'(mag[7:0]) * RES0 + S_W'(mag[15:8]) * RES1
                          + S_W'(mag[23:16]) * RES2 + S_W'(mag[31:24]) * RES3;

            // quotient by rounded-up reciprocal, exact over the folded range
            assign prod_w = P_W'(fold_reg) * P_W'(RECIP[M_W-1:0]);
            assign rem_w  = fold_reg - S_W'(quot_reg) * DIV_S;

            // stage valids
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    fold_v_reg <= 1'b0;
                    quot_v_reg <= 1'b0;
                    done_reg   <= 1'b0;
                end else begin
                    fold_v_reg <= start;
                    quot_v_reg <= fold_v_reg;
                    done_reg   <= quot_v_reg;
                end
            end

            // stage data
            always_ff @(posedge aclk) begin
                if (start) begin
                    fold_reg <= fold_w;
                end
                if (fold_v_reg) begin
                    quot_reg <= prod_w[P_W-1:SHIFT];
                end
                if (quot_v_reg) begin
                    rem_reg <= rem_w[BUCKET_W-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

// ===== rtl/chained_hash_table_core.sv =====
// chained hash table: bucket heads and node pool in two rams, walked by one controller
// flow: bucket unit, head read, one walk step per node visited, result held on m_ready;
//   a miss adds a miss step, a remove hit a free push, node reuse a miss step and a pop;
//   the bucket unit is longer (reciprocal remainder) unless BUCKETS is a power of two
// throughput: one command at a time, s_ready returns the cycle after the result is loaded
// reset: after aresetn the head ram is cleared one bucket at a time with s_ready low
module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int BUCKETS      = BUCKETS_DEF,
    parameter int POOL_NODES   = POOL_NODES_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

`include "assert_macros.svh"

    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_W   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] node;
    } head_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] data;
        logic [NODE_W-1:0]       link;
        logic                    link_ok;
    } node_word_t;

    localparam int HEAD_BITS = $bits(head_word_t);
    localparam int NODE_BITS = $bits(node_word_t);

    // control state
    state_t              state_reg, state_next;
    logic [BUCKET_W-1:0] clr_idx_reg, clr_idx_next;
    logic [NODE_W-1:0]   free_head_reg, free_head_next;
    logic                free_valid_reg, free_valid_next;
    logic [NODE_W:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;

    // working registers of the current command
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [BUCKET_W-1:0]     bucket_reg, bucket_next;
    head_word_t              head_reg, head_next;
    logic [NODE_W-1:0]       cur_idx_reg, cur_idx_next;
    node_word_t              cur_word_reg, cur_word_next;
    logic [NODE_W-1:0]       prev_idx_reg, prev_idx_next;
    node_word_t              prev_word_reg, prev_word_next;
    logic                    prev_ok_reg, prev_ok_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [PAY_W-1:0]        found_reg, found_next;
    out_item_t               out_reg, out_next;

    // memory ports
    logic                head_we;
    logic [BUCKET_W-1:0] head_waddr, head_raddr;
    head_word_t          head_wdata, head_rdata;
    logic [HEAD_BITS-1:0] head_rdata_bits;
    logic                node_we;
    logic [NODE_W-1:0]   node_waddr, node_raddr;
    node_word_t          node_wdata, node_rdata;
    logic [NODE_BITS-1:0] node_rdata_bits;

    // bucket unit
    logic                mod_start, mod_done;
    logic [KEY_W-1:0]    mag;
    logic [BUCKET_W-1:0] mod_bucket;

    logic out_free;
    logic pool_room;

    cht_ram #(
        .WIDTH (HEAD_BITS),
        .DEPTH (BUCKETS),
        .ADDR_W(BUCKET_W)
    ) u_head_ram (
        .aclk (aclk),
        .we   (head_we),
        .waddr(head_waddr),
        .wdata(head_wdata),
        .raddr(head_raddr),
        .rdata(head_rdata_bits)
    );

    cht_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (POOL_NODES),
        .ADDR_W(NODE_W)
    ) u_node_ram (
        .aclk (aclk),
        .we   (node_we),
        .waddr(node_waddr),
        .wdata(node_wdata),
        .raddr(node_raddr),
        .rdata(node_rdata_bits)
    );

    assign head_rdata = head_word_t'(head_rdata_bits);
    assign node_rdata = node_word_t'(node_rdata_bits);

    cht_bucket_mod #(
        .BUCKETS (BUCKETS),
        .BUCKET_W(BUCKET_W)
    ) u_bucket_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mod_start),
        .mag    (mag),
        .done   (mod_done),
        .bucket (mod_bucket)
    );

    // key magnitude as unsigned, most negative key gives 2^31
    assign mag = s_data.key[KEY_W-1] ? (~KEY_W'(s_data.key) + KEY_W'(1)) : KEY_W'(s_data.key);

    assign out_free  = !m_valid_reg || m_ready;
    assign pool_room = free_valid_reg || (fill_reg < (NODE_W+1)'(POOL_NODES));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // controller: next state, memory accesses, result
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_head_next  = free_head_reg;
        free_valid_next = free_valid_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        bucket_next     = bucket_reg;
        head_next       = head_reg;
        cur_idx_next    = cur_idx_reg;
        cur_word_next   = cur_word_reg;
        prev_idx_next   = prev_idx_reg;
        prev_word_next  = prev_word_reg;
        prev_ok_next    = prev_ok_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        out_next        = out_reg;
        mod_start       = 1'b0;
        head_we         = 1'b0;
        head_waddr      = bucket_reg;
        head_wdata      = '0;
        head_raddr      = bucket_reg;
        node_we         = 1'b0;
        node_waddr      = cur_idx_reg;
        node_wdata      = cur_word_reg;
        node_raddr      = cur_idx_reg;

        unique case (state_reg)
            // empty every bucket after reset
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_idx_reg;
                head_wdata = '0;
                clr_idx_next = clr_idx_reg + BUCKET_W'(1);
                if (clr_idx_reg == BUCKET_W'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            // take a command and start the bucket computation
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_data.command;
                    key_next    = KEY_W'(s_data.key);
                    pay_next    = s_data.payload[PAYLOAD_BITS-1:0];
                    status_next = STATUS_OK;
                    found_next  = '0;
                    mod_start   = 1'b1;
                    state_next  = ST_HASH;
                end
            end

            // read the chain head
            ST_HASH: begin
                if (mod_done) begin
                    bucket_next = mod_bucket;
                    head_raddr  = mod_bucket;
                    state_next  = ST_HEAD;
                end
            end

            ST_HEAD: begin
                head_next    = head_rdata;
                prev_ok_next = 1'b0;
                if (head_rdata.ok) begin
                    node_raddr   = head_rdata.node;
                    cur_idx_next = head_rdata.node;
                    state_next   = ST_WALK;
                end else begin
                    state_next = ST_MISS;
                end
            end

            // one node per cycle: compare, then follow the link
            ST_WALK: begin
                cur_word_next = node_rdata;
                if (node_rdata.key == key_reg) begin
                    priority if (cmd_reg == CMD_INSERT) begin
                        node_we         = 1'b1;
                        node_waddr      = cur_idx_reg;
                        node_wdata      = node_rdata;
                        node_wdata.data = pay_reg;
                        state_next      = ST_DONE;
                    end else if (cmd_reg == CMD_REMOVE) begin
                        if (prev_ok_reg) begin
                            node_we            = 1'b1;
                            node_waddr         = prev_idx_reg;
                            node_wdata         = prev_word_reg;
                            node_wdata.link    = node_rdata.link;
                            node_wdata.link_ok = node_rdata.link_ok;
                        end else begin
                            head_we         = 1'b1;
                            head_waddr      = bucket_reg;
                            head_wdata.ok   = node_rdata.link_ok;
                            head_wdata.node = node_rdata.link;
                        end
                        state_next = ST_FREE;
                    end else begin
                        found_next = PAY_W'(node_rdata.data);
                        state_next = ST_DONE;
                    end
                end else begin
                    prev_word_next = node_rdata;
                    prev_idx_next  = cur_idx_reg;
                    prev_ok_next   = 1'b1;
                    if (node_rdata.link_ok) begin
                        node_raddr   = node_rdata.link;
                        cur_idx_next = node_rdata.link;
                    end else begin
                        state_next = ST_MISS;
                    end
                end
            end

            // key absent: allocate on insert (or report full), else report not found
            ST_MISS: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (free_valid_reg) begin
                        node_raddr = free_head_reg;
                        state_next = ST_POP;
                    end else if (pool_room) begin
                        node_we            = 1'b1;
                        node_waddr         = fill_reg[NODE_W-1:0];
                        node_wdata.key     = key_reg;
                        node_wdata.data    = pay_reg;
                        node_wdata.link    = head_reg.node;
                        node_wdata.link_ok = head_reg.ok;
                        head_we            = 1'b1;
                        head_wdata.ok      = 1'b1;
                        head_wdata.node    = fill_reg[NODE_W-1:0];
                        fill_next          = fill_reg + (NODE_W+1)'(1);
                        count_next         = count_reg + CNT_W'(1);
                        state_next         = ST_DONE;
                    end else begin
                        status_next = STATUS_FULL;
                        state_next  = ST_DONE;
                    end
                end else begin
                    status_next = STATUS_MISS;
                    state_next  = ST_DONE;
                end
            end

            // reuse the node at the head of the free list
            ST_POP: begin
                free_head_next     = node_rdata.link;
                free_valid_next    = node_rdata.link_ok;
                node_we            = 1'b1;
                node_waddr         = free_head_reg;
                node_wdata.key     = key_reg;
                node_wdata.data    = pay_reg;
                node_wdata.link    = head_reg.node;
                node_wdata.link_ok = head_reg.ok;
                head_we            = 1'b1;
                head_wdata.ok      = 1'b1;
                head_wdata.node    = free_head_reg;
                count_next         = count_reg + CNT_W'(1);
                state_next         = ST_DONE;
            end

            // push the unlinked node onto the free list
            ST_FREE: begin
                node_we            = 1'b1;
                node_waddr         = cur_idx_reg;
                node_wdata         = cur_word_reg;
                node_wdata.link    = free_head_reg;
                node_wdata.link_ok = free_valid_reg;
                free_head_next     = cur_idx_reg;
                free_valid_next    = 1'b1;
                count_next         = count_reg - CNT_W'(1);
                state_next         = ST_DONE;
            end

            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    out_next.status        = status_reg;
                    out_next.found_payload = found_reg;
                    out_next.entry_count   = count_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_valid_reg <= 1'b0;
            fill_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_valid_reg <= free_valid_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        free_head_reg <= free_head_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        pay_reg       <= pay_next;
        bucket_reg    <= bucket_next;
        head_reg      <= head_next;
        cur_idx_reg   <= cur_idx_next;
        cur_word_reg  <= cur_word_next;
        prev_idx_reg  <= prev_idx_next;
        prev_word_reg <= prev_word_next;
        prev_ok_reg   <= prev_ok_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        out_reg       <= out_next;
    end

    // checks
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "command overlap")
    `ASSERT_IMPLIES(a_mod_in_hash, aclk, aresetn, mod_done, state_reg == ST_HASH, "stray bucket result")
    `ASSERT_IMPLIES(a_empty_pool, aclk, aresetn, fill_reg == '0, (count_reg == '0) && !free_valid_reg, "entries without nodes")
    `ASSERT_IMPLIES(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= (NODE_W+1)'(POOL_NODES), "fill count past pool")

endmodule
